### src/lcd_decimal_nibble_writer_defines.svh
// Assertion macros for the LCD decimal nibble writer checker.
`ifndef LCD_DECIMAL_NIBBLE_WRITER_DEFINES_SVH
`define LCD_DECIMAL_NIBBLE_WRITER_DEFINES_SVH

// Same-cycle implication, sampled on clk, held off during reset.
`define LDNW_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ldnw: same-cycle check failed");

// Next-cycle implication, sampled on clk, held off during reset.
`define LDNW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ldnw: next-cycle check failed");

`endif

### src/ldnw_pkg.sv
// Types, constants and microcode for the LCD decimal nibble writer.
package ldnw_pkg;

    localparam int MAX_DIGITS    = 10;
    localparam int VALUE_W       = 32;
    localparam int BCD_W         = 4 * MAX_DIGITS;
    localparam int NDIG_W        = $clog2(MAX_DIGITS + 1);
    localparam int BITS_PER_STEP = 2;
    localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
    localparam int ITER_W        = $clog2(CONV_STEPS);

    localparam logic [1:0] ROW_LINE_ONE  = 2'd1;
    localparam logic [7:0] LINE_ONE_BASE = 8'h80;
    localparam logic [7:0] LINE_TWO_BASE = 8'hC0;
    localparam logic [7:0] ASCII_ZERO    = 8'd48;
    localparam logic [3:0] DIGIT_ADJ_MIN = 4'd5;
    localparam logic [3:0] DIGIT_ADJ     = 4'd3;

    typedef struct packed {
        logic [1:0]         row;
        logic [7:0]         column;
        logic [VALUE_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic       reg_select;
        logic [3:0] nibble;
        logic       last;
    } result_t;

    typedef enum logic [2:0] {
        STEP_IDLE,
        STEP_CONV,
        STEP_TRIM,
        STEP_CMD_HI,
        STEP_CMD_LO,
        STEP_CHR_HI,
        STEP_CHR_LO
    } step_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_DABBLE,
        OP_TRIM,
        OP_NEXT
    } ctl_op_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_START,
        COND_ITER,
        COND_TRIM,
        COND_MORE
    } cond_t;

    typedef enum logic [1:0] {
        SEL_CMD_HI,
        SEL_CMD_LO,
        SEL_CHR_HI,
        SEL_CHR_LO
    } nib_sel_t;

    typedef struct packed {
        ctl_op_t  op;
        cond_t    cond;
        step_t    jmp;
        step_t    nxt;
        logic     emit;
        logic     rs;
        nib_sel_t sel;
    } ctl_word_t;

    typedef struct packed {
        logic start;
        logic iter_more;
        logic can_trim;
        logic more_digits;
    } flags_t;

    function automatic ctl_word_t ucode_rom(input step_t s);
        ctl_word_t w;
        unique case (s)
            STEP_IDLE:   w = '{op: OP_LOAD, cond: COND_START, jmp: STEP_CONV,
                               nxt: STEP_IDLE, emit: 1'b0, rs: 1'b0, sel: SEL_CMD_HI};
            STEP_CONV:   w = '{op: OP_DABBLE, cond: COND_ITER, jmp: STEP_CONV,
                               nxt: STEP_TRIM, emit: 1'b0, rs: 1'b0, sel: SEL_CMD_HI};
            STEP_TRIM:   w = '{op: OP_TRIM, cond: COND_TRIM, jmp: STEP_TRIM,
                               nxt: STEP_CMD_HI, emit: 1'b0, rs: 1'b0, sel: SEL_CMD_HI};
            STEP_CMD_HI: w = '{op: OP_NONE, cond: COND_NEVER, jmp: STEP_IDLE,
                               nxt: STEP_CMD_LO, emit: 1'b1, rs: 1'b0, sel: SEL_CMD_HI};
            STEP_CMD_LO: w = '{op: OP_NONE, cond: COND_NEVER, jmp: STEP_IDLE,
                               nxt: STEP_CHR_HI, emit: 1'b1, rs: 1'b0, sel: SEL_CMD_LO};
            STEP_CHR_HI: w = '{op: OP_NONE, cond: COND_NEVER, jmp: STEP_IDLE,
                               nxt: STEP_CHR_LO, emit: 1'b1, rs: 1'b1, sel: SEL_CHR_HI};
            STEP_CHR_LO: w = '{op: OP_NEXT, cond: COND_MORE, jmp: STEP_CMD_HI,
                               nxt: STEP_IDLE, emit: 1'b1, rs: 1'b1, sel: SEL_CHR_LO};
            default:     w = '{op: OP_NONE, cond: COND_NEVER, jmp: STEP_IDLE,
                               nxt: STEP_IDLE, emit: 1'b0, rs: 1'b0, sel: SEL_CMD_HI};
        endcase
        return w;
    endfunction

endpackage

### src/ldnw_seq.sv
// Microcode sequencer: step counter, control store and conditional jumps.
module ldnw_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ldnw_pkg::flags_t     flags,
    output ldnw_pkg::ctl_word_t  ctl,
    output logic                 idle
);
    import ldnw_pkg::*;

    step_t step_reg;
    step_t step_next;
    logic  hit;

    always_comb
    begin
        ctl  = ucode_rom(step_reg);
        idle = (step_reg == STEP_IDLE);
    end

    always_comb
    begin
        unique case (ctl.cond)
            COND_NEVER: hit = 1'b0;
            COND_START: hit = flags.start;
            COND_ITER:  hit = flags.iter_more;
            COND_TRIM:  hit = flags.can_trim;
            COND_MORE:  hit = flags.more_digits;
            default:    hit = 1'b0;
        endcase
        step_next = hit ? ctl.jmp : ctl.nxt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

### src/ldnw_dp.sv
// Datapath: shift-and-add-3 decimal conversion, digit queue and nibble select.
module ldnw_dp (
    input  logic                 clk,
    input  logic                 start,
    input  ldnw_pkg::item_t      item,
    input  ldnw_pkg::ctl_word_t  ctl,
    output ldnw_pkg::flags_t     flags,
    output ldnw_pkg::result_t    res
);
    import ldnw_pkg::*;

    logic [VALUE_W-1:0] bin_reg,  bin_next;
    logic [BCD_W-1:0]   bcd_reg,  bcd_next;
    logic [ITER_W-1:0]  iter_reg, iter_next;
    logic [NDIG_W-1:0]  ndig_reg, ndig_next;
    logic [7:0]         addr_reg, addr_next;
    logic               ovf_reg,  ovf_next;

    logic [BCD_W-1:0]   dab_bcd;
    logic [VALUE_W-1:0] dab_bin;
    logic               dab_ovf;
    logic [3:0]         top_digit;
    logic [7:0]         char_byte;
    logic [7:0]         line_base;

    always_comb
    begin
        dab_bcd = bcd_reg;
        dab_bin = bin_reg;
        dab_ovf = ovf_reg;
        for (int k = 0; k < BITS_PER_STEP; k++)
        begin
            for (int d = 0; d < MAX_DIGITS; d++)
            begin
                if (dab_bcd[4*d +: 4] >= DIGIT_ADJ_MIN)
                begin
                    dab_bcd[4*d +: 4] = dab_bcd[4*d +: 4] + DIGIT_ADJ;
                end
            end
            dab_ovf = dab_ovf | dab_bcd[BCD_W-1];
            {dab_bcd, dab_bin} = {dab_bcd[BCD_W-2:0], dab_bin, 1'b0};
        end
    end

    always_comb
    begin
        top_digit = bcd_reg[BCD_W-1 -: 4];
        char_byte = ASCII_ZERO + {4'h0, top_digit};
        line_base = (item.row == ROW_LINE_ONE) ? LINE_ONE_BASE : LINE_TWO_BASE;

        flags.start       = start;
        flags.iter_more   = (iter_reg != ITER_W'(CONV_STEPS - 1));
        flags.more_digits = (ndig_reg != NDIG_W'(1));
        flags.can_trim    = (top_digit == 4'h0) && flags.more_digits && !ovf_reg;
    end

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        iter_next = iter_reg;
        ndig_next = ndig_reg;
        addr_next = addr_reg;
        ovf_next  = ovf_reg;
        unique case (ctl.op)
            OP_LOAD:
            begin
                if (start)
                begin
                    bin_next  = item.value;
                    bcd_next  = '0;
                    iter_next = '0;
                    ndig_next = NDIG_W'(MAX_DIGITS);
                    addr_next = line_base + item.column - 8'd1;
                    ovf_next  = 1'b0;
                end
            end
            OP_DABBLE:
            begin
                bin_next  = dab_bin;
                bcd_next  = dab_bcd;
                ovf_next  = dab_ovf;
                iter_next = iter_reg + ITER_W'(1);
            end
            OP_TRIM:
            begin
                if (flags.can_trim)
                begin
                    bcd_next  = {bcd_reg[BCD_W-5:0], 4'h0};
                    ndig_next = ndig_reg - NDIG_W'(1);
                end
            end
            OP_NEXT:
            begin
                bcd_next  = {bcd_reg[BCD_W-5:0], 4'h0};
                ndig_next = ndig_reg - NDIG_W'(1);
                addr_next = addr_reg + 8'd1;
            end
            OP_NONE:
            begin
                bin_next = bin_reg;
            end
            default:
            begin
                bin_next = bin_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        iter_reg <= iter_next;
        ndig_reg <= ndig_next;
        addr_reg <= addr_next;
        ovf_reg  <= ovf_next;
    end

    always_comb
    begin
        res.reg_select = ctl.rs;
        res.last       = (ctl.op == OP_NEXT) && !flags.more_digits;
        unique case (ctl.sel)
            SEL_CMD_HI: res.nibble = addr_reg[7:4];
            SEL_CMD_LO: res.nibble = addr_reg[3:0];
            SEL_CHR_HI: res.nibble = char_byte[7:4];
            SEL_CHR_LO: res.nibble = char_byte[3:0];
            default:    res.nibble = char_byte[3:0];
        endcase
    end

endmodule

### src/lcd_decimal_nibble_writer.sv
// Top level of the LCD decimal nibble writer.
// Use: drive item (row, column, value) and raise start; the transaction is
// taken at the rising edge where start is high and busy is low. busy then
// stays high until the final nibble of that value has been issued.
// The value is converted to decimal two bits per cycle, then
// leading zero digits are dropped one per cycle, then each digit leaves
// as four nibbles: set-address command high/low (reg_select 0), then the
// ASCII character high/low (reg_select 1), one nibble per cycle.
// Each nibble appears on result for exactly one cycle with strobe high;
// result.last marks the final nibble of the value.
// For a value of n decimal digits busy covers the conversion loop, the
// one-digit-per-cycle trim of leading zeros and the four nibbles of each
// digit; the first nibble shows once the sequencer is through the trim.
// Reset clears the sequencer to idle and drops strobe. The receiver
// cannot stall: nibbles are issued at the fixed rate above.
module lcd_decimal_nibble_writer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ldnw_pkg::item_t   item,
    output logic              strobe,
    output ldnw_pkg::result_t result
);
    import ldnw_pkg::*;

    ctl_word_t ctl;
    flags_t    flags;
    result_t   res;
    logic      idle;

    logic      strobe_reg;
    result_t   result_reg;

    ldnw_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctl   (ctl),
        .idle  (idle)
    );

    ldnw_dp u_dp (
        .clk   (clk),
        .start (start),
        .item  (item),
        .ctl   (ctl),
        .flags (flags),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= ctl.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= res;
    end

    assign busy   = !idle;
    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

### src/ldnw_checker.sv
// Port-level checker for the LCD decimal nibble writer, with its bind.
`include "lcd_decimal_nibble_writer_defines.svh"

module ldnw_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              strobe,
    input ldnw_pkg::result_t result
);

    `LDNW_ASSERT_NEXT(a_accept_sets_busy, start && !busy, busy)
    `LDNW_ASSERT_NEXT(a_last_then_quiet, strobe && result.last, !strobe)
    `LDNW_ASSERT_IMPLIES(a_mid_value_busy, strobe && !result.last, busy)
    `LDNW_ASSERT_NEXT(a_idle_no_nibble, !busy, !strobe)
    `LDNW_ASSERT_NEXT(a_command_continues, strobe && !result.reg_select, strobe)

endmodule

bind lcd_decimal_nibble_writer ldnw_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
);

### bench/tb_top.sv
// Testbench for the LCD decimal nibble writer: directed table, random values, nibble predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ldnw_pkg::*;

    localparam logic RS_CMD    = 1'b0;
    localparam logic RS_CHR    = 1'b1;
    localparam bit   TYPED     = 1'b1;
    localparam bit   PREDICTED = 1'b0;
    localparam int   N_DIRECTED = 20;
    localparam int   N_RANDOM   = 160;
    localparam int   DRAIN_CYCLES = 80;

    typedef struct {
        item_t            stim;
        bit               typed;
        result_t [0:3]    want;
    } directed_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    item_t   item = '0;
    logic    busy;
    logic    strobe;
    result_t lcd_result;

    result_t nibbles_due [$];
    int      mismatch_count = 0;

    directed_t directed_rows [N_DIRECTED] = '{
        '{'{2'd1, 8'd1, 32'd0}, TYPED,
          '{'{RS_CMD, 4'h8, 1'b0}, '{RS_CMD, 4'h0, 1'b0},
            '{RS_CHR, 4'h3, 1'b0}, '{RS_CHR, 4'h0, 1'b1}}},
        '{'{2'd0, 8'd1, 32'd0}, TYPED,
          '{'{RS_CMD, 4'hC, 1'b0}, '{RS_CMD, 4'h0, 1'b0},
            '{RS_CHR, 4'h3, 1'b0}, '{RS_CHR, 4'h0, 1'b1}}},
        '{'{2'd1, 8'd0, 32'd9}, TYPED,
          '{'{RS_CMD, 4'h7, 1'b0}, '{RS_CMD, 4'hF, 1'b0},
            '{RS_CHR, 4'h3, 1'b0}, '{RS_CHR, 4'h9, 1'b1}}},
        '{'{2'd2, 8'd255, 32'd5}, TYPED,
          '{'{RS_CMD, 4'hB, 1'b0}, '{RS_CMD, 4'hE, 1'b0},
            '{RS_CHR, 4'h3, 1'b0}, '{RS_CHR, 4'h5, 1'b1}}},
        '{'{2'd3, 8'd64, 32'd7}, TYPED,
          '{'{RS_CMD, 4'hF, 1'b0}, '{RS_CMD, 4'hF, 1'b0},
            '{RS_CHR, 4'h3, 1'b0}, '{RS_CHR, 4'h7, 1'b1}}},
        '{'{2'd1, 8'd128, 32'd1}, TYPED,
          '{'{RS_CMD, 4'hF, 1'b0}, '{RS_CMD, 4'hF, 1'b0},
            '{RS_CHR, 4'h3, 1'b0}, '{RS_CHR, 4'h1, 1'b1}}},
        '{'{2'd1, 8'd1, 32'hFFFF_FFFF}, PREDICTED, '0},
        '{'{2'd0, 8'd250, 32'hFFFF_FFFF}, PREDICTED, '0},
        '{'{2'd2, 8'hAA, 32'h5555_5555}, PREDICTED, '0},
        '{'{2'd3, 8'h55, 32'hAAAA_AAAA}, PREDICTED, '0},
        '{'{2'd1, 8'd255, 32'd12345}, PREDICTED, '0},
        '{'{2'd0, 8'd0, 32'd10}, PREDICTED, '0},
        '{'{2'd1, 8'd16, 32'd99}, PREDICTED, '0},
        '{'{2'd2, 8'd40, 32'd100}, PREDICTED, '0},
        '{'{2'd3, 8'd1, 32'd1000000000}, PREDICTED, '0},
        '{'{2'd1, 8'd2, 32'd999999999}, PREDICTED, '0},
        '{'{2'd0, 8'd3, 32'd1234567890}, PREDICTED, '0},
        '{'{2'd1, 8'd200, 32'h8000_0000}, PREDICTED, '0},
        '{'{2'd2, 8'd128, 32'h7FFF_FFFF}, PREDICTED, '0},
        '{'{2'd3, 8'd0, 32'd0}, PREDICTED, '0}
    };

    lcd_decimal_nibble_writer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .strobe (strobe),
        .result (lcd_result)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void push_decimal_nibbles(input item_t it);
        logic [31:0] rest;
        logic [3:0]  digit [MAX_DIGITS];
        logic [7:0]  addr;
        logic [7:0]  ch;
        logic        final_digit;
        int          count;
        rest  = it.value;
        count = 0;
        do
        begin
            digit[count] = 4'(rest % 10);
            rest = rest / 10;
            count++;
        end
        while (rest != 0 && count < MAX_DIGITS);
        for (int i = 0; i < count; i++)
        begin
            addr = 8'(((it.row == ROW_LINE_ONE) ? LINE_ONE_BASE : LINE_TWO_BASE)
                      + it.column + i - 1);
            ch = ASCII_ZERO + 8'(digit[count - 1 - i]);
            final_digit = (i == count - 1);
            nibbles_due.push_back('{RS_CMD, addr[7:4], 1'b0});
            nibbles_due.push_back('{RS_CMD, addr[3:0], 1'b0});
            nibbles_due.push_back('{RS_CHR, ch[7:4], 1'b0});
            nibbles_due.push_back('{RS_CHR, ch[3:0], final_digit});
        end
    endfunction

    function automatic item_t random_item();
        item_t           it;
        int              pick;
        int              ndig;
        longint unsigned lo;
        longint unsigned hi;
        it.row = 2'($urandom_range(3));
        if ($urandom_range(99) < 20)
            it.column = (($urandom_range(1) != 0) ? 8'd255 : 8'd0) ^ 8'($urandom_range(1));
        else
            it.column = 8'($urandom_range(255));
        pick = $urandom_range(99);
        if (pick < 15)
            it.value = 32'($urandom_range(9));
        else if (pick < 25)
            it.value = 32'hFFFF_FFFF - 32'($urandom_range(3));
        else if (pick < 85)
        begin
            ndig = $urandom_range(1, MAX_DIGITS);
            lo = 1;
            repeat (ndig - 1) lo = lo * 10;
            hi = lo * 10 - 1;
            if (hi > 64'hFFFF_FFFF)
                hi = 64'hFFFF_FFFF;
            it.value = 32'(lo + ({$urandom, $urandom} % (hi - lo + 1)));
        end
        else
            it.value = $urandom;
        return it;
    endfunction

    task automatic report_mismatch(input string field, input logic [3:0] got,
                                   input logic [3:0] want);
        $display("%0t ns: nibble mismatch on %s, got %h, want %h", $time, field, got, want);
        mismatch_count++;
    endtask

    task automatic send_transaction(input item_t it, input bit typed,
                                    input result_t [0:3] want, input bit may_idle);
        int gap;
        start <= 1'b1;
        item  <= it;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if (typed)
        begin
            for (int i = 0; i < 4; i++)
                nibbles_due.push_back(want[i]);
        end
        else
            push_decimal_nibbles(it);
        if (may_idle && $urandom_range(99) < 35)
        begin
            gap = ($urandom_range(3) == 0) ? $urandom_range(9, 70) : $urandom_range(1, 8);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin : check_nibbles
        result_t due;
        if (rst_n && strobe === 1'b1)
        begin
            if (nibbles_due.size() == 0)
                report_mismatch("unexpected strobe", 4'(lcd_result), 4'h0);
            else
            begin
                due = nibbles_due.pop_front();
                if (lcd_result.reg_select !== due.reg_select)
                    report_mismatch("reg_select", 4'(lcd_result.reg_select),
                                    4'(due.reg_select));
                if (lcd_result.nibble !== due.nibble)
                    report_mismatch("nibble", lcd_result.nibble, due.nibble);
                if (lcd_result.last !== due.last)
                    report_mismatch("last", 4'(lcd_result.last), 4'(due.last));
            end
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_rows[k])
            send_transaction(directed_rows[k].stim, directed_rows[k].typed,
                             directed_rows[k].want, 1'b1);
        for (int k = 0; k < N_RANDOM; k++)
        begin
            if (k == 120)
            begin
                start <= 1'b0;
                while (nibbles_due.size() != 0)
                    @(posedge clk);
                repeat (8) @(posedge clk);
            end
            send_transaction(random_item(), PREDICTED, '0, (k < 40 || k >= 100));
        end
        start <= 1'b0;
        while (nibbles_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

### files.f
+incdir+src
src/ldnw_pkg.sv
src/ldnw_seq.sv
src/ldnw_dp.sv
src/lcd_decimal_nibble_writer.sv
src/ldnw_checker.sv
bench/tb_top.sv
